// ----- src/sacl_pkg.sv -----
`default_nettype none
package sacl_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;
  localparam int SET_W        = MAX_SET_BITS;
  localparam int ADDR_W       = 64;
  localparam int TAG_W        = 64;
  localparam int RANK_W       = 3;
  localparam int CNT_W        = 32;
  localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAYS_W       = $clog2(MAX_WAYS + 1);
  localparam int SB_W         = 7;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'((1 << RANK_W) - 1);

  // Register widths
  localparam int SETB_W  = 3;
  localparam int BLKB_W  = 6;
  localparam int WAYSR_W = 4;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_SET_BITS    = 2'd0,
    REG_BLOCK_BITS  = 2'd1,
    REG_WAYS_IN_USE = 2'd2
  } reg_idx_t;

  localparam int OUT_DATA_W = 104;

  typedef struct packed {
    logic [SETB_W-1:0]  set_bits;
    logic [BLKB_W-1:0]  block_bits;
    logic [WAYSR_W-1:0] ways_in_use;
  } cfg_t;

  // One cache set, read and written back as a whole row
  typedef struct packed {
    logic [MAX_WAYS-1:0]              valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0]  rank;
    logic [MAX_WAYS-1:0][TAG_W-1:0]   tag;
  } set_row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_UPD_A,
    ST_RD_B,
    ST_UPD_B
  } ctrl_state_t;

  typedef struct packed {
    logic latch;   // capture a new input item
    logic rd;      // read the set row
    logic commit;  // write the row back, bump totals, load the result
    logic last;    // result closes the item
  } dp_cmd_t;

  typedef struct packed {
    logic modify;     // current item makes two accesses
    logic slot_free;  // output register can take a result
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- src/sacl_ctrl.sv -----
`default_nettype none
module sacl_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  sacl_pkg::dp_stat_t    stat,
  output sacl_pkg::dp_cmd_t     cmd
);

  sacl_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sacl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      sacl_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = sacl_pkg::ST_RD_A;
        end
      end
      sacl_pkg::ST_RD_A: begin
        cmd.rd    = 1'b1;
        state_nxt = sacl_pkg::ST_UPD_A;
      end
      sacl_pkg::ST_UPD_A: begin
        if (stat.slot_free) begin
          cmd.commit = 1'b1;
          if (stat.modify) begin
            state_nxt = sacl_pkg::ST_RD_B;
          end else begin
            cmd.last = 1'b1;
            if (in_valid) begin
              cmd.latch = 1'b1;
              state_nxt = sacl_pkg::ST_RD_A;
            end else begin
              state_nxt = sacl_pkg::ST_IDLE;
            end
          end
        end
      end
      sacl_pkg::ST_RD_B: begin
        cmd.rd    = 1'b1;
        state_nxt = sacl_pkg::ST_UPD_B;
      end
      sacl_pkg::ST_UPD_B: begin
        if (stat.slot_free) begin
          cmd.commit = 1'b1;
          cmd.last   = 1'b1;
          if (in_valid) begin
            cmd.latch = 1'b1;
            state_nxt = sacl_pkg::ST_RD_A;
          end else begin
            state_nxt = sacl_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sacl_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready = cmd.latch;

endmodule
`default_nettype wire

// ----- src/sacl_dp.sv -----
`default_nettype none
module sacl_dp (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  sacl_pkg::cfg_t                       cfg,
  input  wire [sacl_pkg::ADDR_W-1:0]           in_addr,
  input  wire                                  in_mode,
  input  sacl_pkg::dp_cmd_t                    cmd,
  output sacl_pkg::dp_stat_t                   stat,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [sacl_pkg::OUT_DATA_W-1:0]      out_data,
  output logic                                 out_last
);

  // Address decode, registered at item capture
  logic [sacl_pkg::SETB_W-1:0]  s_eff;
  logic [sacl_pkg::SB_W-1:0]    sb;
  logic [sacl_pkg::SET_W:0]     set_span;
  logic [sacl_pkg::SET_W-1:0]   set_mask;
  logic [sacl_pkg::TAG_W-1:0]   tag_calc;
  logic [sacl_pkg::SET_W-1:0]   set_calc;

  logic [sacl_pkg::TAG_W-1:0]   tag_r;
  logic [sacl_pkg::SET_W-1:0]   set_r;
  logic                         modify_r;

  always_comb begin
    s_eff    = (cfg.set_bits > sacl_pkg::SETB_W'(sacl_pkg::MAX_SET_BITS)) ?
               sacl_pkg::SETB_W'(sacl_pkg::MAX_SET_BITS) : cfg.set_bits;
    sb       = sacl_pkg::SB_W'(s_eff) + sacl_pkg::SB_W'(cfg.block_bits);
    tag_calc = (sb >= sacl_pkg::SB_W'(sacl_pkg::TAG_W)) ? '0 : (in_addr >> sb[5:0]);
    set_span = (sacl_pkg::SET_W+1)'(1) << s_eff;
    set_mask = sacl_pkg::SET_W'(set_span - (sacl_pkg::SET_W+1)'(1));
    set_calc = sacl_pkg::SET_W'(in_addr >> cfg.block_bits) & set_mask;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      tag_r    <= tag_calc;
      set_r    <= set_calc;
      modify_r <= in_mode;
    end
  end

  // Set memory; a row never written since reset reads as all invalid, rank zero
  sacl_pkg::set_row_t mem [sacl_pkg::NUM_SETS];
  sacl_pkg::set_row_t rd_row_r;
  logic [sacl_pkg::NUM_SETS-1:0] row_ok_r;
  logic                          rd_ok_r;
  sacl_pkg::set_row_t            row_nxt;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[set_r] <= row_nxt;
    end
    if (cmd.rd) begin
      rd_row_r <= mem[set_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r <= '0;
      rd_ok_r  <= 1'b0;
    end else begin
      if (cmd.commit) begin
        row_ok_r[set_r] <= 1'b1;
      end
      if (cmd.rd) begin
        rd_ok_r <= row_ok_r[set_r];
      end
    end
  end

  // Lookup and LRU update
  logic [sacl_pkg::WAYS_W-1:0]                          ways_eff;
  logic [sacl_pkg::MAX_WAYS-1:0]                        in_use;
  logic [sacl_pkg::MAX_WAYS-1:0]                        vld;
  logic [sacl_pkg::MAX_WAYS-1:0][sacl_pkg::RANK_W-1:0]  rnk;
  logic [sacl_pkg::MAX_WAYS-1:0]                        hit_v;
  logic [sacl_pkg::MAX_WAYS-1:0]                        inv_v;
  logic                                                 hit;
  logic                                                 has_inv;
  logic                                                 evict;
  logic [sacl_pkg::WAY_W-1:0]                           hit_way;
  logic [sacl_pkg::WAY_W-1:0]                           inv_way;
  logic [sacl_pkg::WAY_W-1:0]                           vic_way;
  logic [sacl_pkg::WAY_W-1:0]                           tgt;
  logic [sacl_pkg::RANK_W-1:0]                          best;
  logic [sacl_pkg::RANK_W-1:0]                          old_rank;
  logic                                                 was_valid;

  always_comb begin
    if (cfg.ways_in_use == '0) begin
      ways_eff = sacl_pkg::WAYS_W'(1);
    end else if (cfg.ways_in_use > sacl_pkg::WAYSR_W'(sacl_pkg::MAX_WAYS)) begin
      ways_eff = sacl_pkg::WAYS_W'(sacl_pkg::MAX_WAYS);
    end else begin
      ways_eff = sacl_pkg::WAYS_W'(cfg.ways_in_use);
    end

    vld = rd_ok_r ? rd_row_r.valid : '0;
    rnk = rd_ok_r ? rd_row_r.rank  : '0;

    for (int w = 0; w < sacl_pkg::MAX_WAYS; w++) begin
      in_use[w] = sacl_pkg::WAYS_W'(w) < ways_eff;
      hit_v[w]  = in_use[w] && vld[w] && (rd_row_r.tag[w] == tag_r);
      inv_v[w]  = in_use[w] && !vld[w];
    end
    hit     = |hit_v;
    has_inv = |inv_v;

    // Lowest matching way wins
    hit_way = '0;
    inv_way = '0;
    for (int w = sacl_pkg::MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_v[w]) hit_way = sacl_pkg::WAY_W'(w);
      if (inv_v[w]) inv_way = sacl_pkg::WAY_W'(w);
    end

    // Oldest way, lowest index on a tie
    vic_way = '0;
    best    = rnk[0];
    for (int w = 1; w < sacl_pkg::MAX_WAYS; w++) begin
      if (in_use[w] && (rnk[w] > best)) begin
        best    = rnk[w];
        vic_way = sacl_pkg::WAY_W'(w);
      end
    end

    evict     = !hit && !has_inv;
    was_valid = hit || !has_inv;
    tgt       = hit ? hit_way : (has_inv ? inv_way : vic_way);
    old_rank  = rnk[tgt];

    row_nxt.valid = vld;
    row_nxt.rank  = rnk;
    row_nxt.tag   = rd_row_r.tag;
    for (int w = 0; w < sacl_pkg::MAX_WAYS; w++) begin
      if (sacl_pkg::WAY_W'(w) == tgt) begin
        row_nxt.valid[w] = 1'b1;
        row_nxt.rank[w]  = '0;
        row_nxt.tag[w]   = tag_r;
      end else if (in_use[w] && vld[w] && (!was_valid || (rnk[w] < old_rank)) &&
                   (rnk[w] < sacl_pkg::RANK_MAX)) begin
        row_nxt.rank[w] = rnk[w] + sacl_pkg::RANK_W'(1);
      end
    end
  end

  // Running totals and output register
  logic [sacl_pkg::CNT_W-1:0] hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic [sacl_pkg::CNT_W-1:0] hit_cnt_nxt, miss_cnt_nxt, evict_cnt_nxt;
  logic                       out_valid_r;
  logic [sacl_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                       out_last_r;

  assign hit_cnt_nxt   = hit_cnt_r   + sacl_pkg::CNT_W'(hit);
  assign miss_cnt_nxt  = miss_cnt_r  + sacl_pkg::CNT_W'(!hit);
  assign evict_cnt_nxt = evict_cnt_r + sacl_pkg::CNT_W'(evict);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        evict_cnt_r <= evict_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {5'b0, evict_cnt_nxt, miss_cnt_nxt, hit_cnt_nxt, evict, !hit, hit};
      out_last_r <= cmd.last;
    end
  end

  assign stat.modify    = modify_r;
  assign stat.slot_free = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire

// ----- src/set_assoc_cache_lru_sim.sv -----
`default_nettype none
// Access: a set row read, then lookup and write-back; the result shows in the output
//   register the cycle after the write-back. A plain item makes one access, a modify
//   item two; the next item is taken with the last write-back of the current one, and
//   reads and write-backs of the set memory never overlap; a held result stalls the write-back.
// Reset (rst_n, synchronous): cache empty, all LRU ranks zero, totals zero,
//   set_bits = 1, block_bits = 0, ways_in_use = 1. No clearing pass is needed.
module set_assoc_cache_lru_sim (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // Input stream
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  input  wire [63:0]                            in_tdata,   // [63:0] access_address
  input  wire [0:0]                             in_tuser,   // [0] mode
  // Result stream
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  // [0] was_hit, [1] was_miss, [2] was_evict, [34:3] hit_total,
  // [66:35] miss_total, [98:67] evict_total, [103:99] zero
  output logic [sacl_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tlast,  // last_of_item
  // Configuration port
  input  wire                                   cfg_psel,
  input  wire                                   cfg_penable,
  input  wire                                   cfg_pwrite,
  input  wire [sacl_pkg::PADDR_W-1:0]           cfg_paddr,
  input  wire [sacl_pkg::PDATA_W-1:0]           cfg_pwdata,
  output logic [sacl_pkg::PDATA_W-1:0]          cfg_prdata,
  output logic                                  cfg_pready
);

  // Configuration registers; a write lands at the access phase
  sacl_pkg::cfg_t cfg_r;
  logic           cfg_wr;
  logic [1:0]     reg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_bits    <= sacl_pkg::SETB_W'(1);
      cfg_r.block_bits  <= '0;
      cfg_r.ways_in_use <= sacl_pkg::WAYSR_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        sacl_pkg::REG_SET_BITS:    cfg_r.set_bits    <= cfg_pwdata[sacl_pkg::SETB_W-1:0];
        sacl_pkg::REG_BLOCK_BITS:  cfg_r.block_bits  <= cfg_pwdata[sacl_pkg::BLKB_W-1:0];
        sacl_pkg::REG_WAYS_IN_USE: cfg_r.ways_in_use <= cfg_pwdata[sacl_pkg::WAYSR_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      sacl_pkg::REG_SET_BITS:    cfg_prdata = sacl_pkg::PDATA_W'(cfg_r.set_bits);
      sacl_pkg::REG_BLOCK_BITS:  cfg_prdata = sacl_pkg::PDATA_W'(cfg_r.block_bits);
      sacl_pkg::REG_WAYS_IN_USE: cfg_prdata = sacl_pkg::PDATA_W'(cfg_r.ways_in_use);
      default:                   cfg_prdata = '0;
    endcase
  end

  // Controller sequences read / write-back per access; datapath holds the memory
  sacl_pkg::dp_cmd_t  cmd;
  sacl_pkg::dp_stat_t stat;

  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sacl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_addr   (in_tdata),
    .in_mode   (in_tuser[0]),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule
`default_nettype wire
